>>> rtl/aets_pkg.sv
// ----------------------------------------------------------------------------
// aets_pkg
// Shared types and codes of the aging entity table smoother.
// ----------------------------------------------------------------------------
package aets_pkg;

  // command codes (in_tuser)
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // result status codes (out_tuser)
  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_REFRESH  = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TICKED   = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_SCENE_KEY  = 2'd0;
  localparam logic [1:0] CFG_INVERT_Y   = 2'd1;
  localparam logic [1:0] CFG_TTL_RELOAD = 2'd2;

  // floor(n/5) = (n * RECIP5) >> 34, exact for n < 2**32
  localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;
  // bias 5 * 2**24 keeps the dividend positive
  localparam logic [26:0] DIV_BIAS = 27'd83886080;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic [15:0]        id;
    logic [3:0]         color;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] sz;
    logic [7:0]         ttl;
  } rec_t;

endpackage

>>> rtl/aging_entity_table_smoother_unit.sv
// ----------------------------------------------------------------------------
// aging_entity_table_smoother_unit
// Slot table of tracked entities with time-to-live aging and smoothing.
// ----------------------------------------------------------------------------
// An update scans the table at one memory read a cycle, then does a
// read-modify-write of the chosen slot; a tick reads every slot and runs each
// live one through the shared smoothing unit, one axis at a time.
// One item at a time; the next is taken while the result waits in out_tdata.
// Synchronous reset clears control, config and slot valid bits, not the memory.
// ----------------------------------------------------------------------------
module aging_entity_table_smoother_unit #(
  parameter int SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] command
  input  logic [1:0]   in_tuser,
  // [15:0] update_key, [31:16] entity_id, [35:32] color_code,
  // [51:36] target_x_in, [67:52] target_y_in, [83:68] target_z_in,
  // [87:84] read_slot
  input  logic [87:0]  in_tdata,
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status
  output logic [2:0]   out_tuser,
  // [3:0] slot_used, [19:4] id_out, [23:20] color_out, [47:24] current_x_out,
  // [71:48] current_y_out, [95:72] current_z_out, [103:96] ttl_out
  output logic [103:0] out_tdata,
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_USCAN = 4'd1;
  localparam logic [3:0] S_UDEC  = 4'd2;
  localparam logic [3:0] S_URD   = 4'd3;
  localparam logic [3:0] S_UWR   = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_TLD   = 4'd6;
  localparam logic [3:0] S_TMUL  = 4'd7;
  localparam logic [3:0] S_TACC  = 4'd8;
  localparam logic [3:0] S_TWR   = 4'd9;
  localparam logic [3:0] S_RRD   = 4'd10;
  localparam logic [3:0] S_RLD   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // axis selected for the shared smoothing unit
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [15:0]        id;
    logic [3:0]         color;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic [3:0]         rs;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [15:0]        id;
    logic [3:0]         color;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [7:0]         ttl;
  } res_t;

  // ---- control state (reset) ----
  logic [3:0]       state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [15:0]      scene_key_r, scene_key_nxt;
  logic             invert_y_r, invert_y_nxt;
  logic [7:0]       ttl_reload_r, ttl_reload_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             pend_r, pend_nxt;
  logic             match_r, match_nxt;
  logic             free_r, free_nxt;

  // ---- payload / working registers ----
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    cmp_r, cmp_nxt;     // address of last memory read
  logic [SW-1:0]    msel_r, msel_nxt;   // first live slot with same id
  logic [SW-1:0]    fsel_r, fsel_nxt;   // first free slot
  logic [SW-1:0]    sel_r, sel_nxt;     // slot chosen by an update
  logic [1:0]       axis_r, axis_nxt;
  item_t            item_r, item_nxt;
  res_t             res_r, res_nxt;
  res_t             out_data_r, out_data_nxt;
  aets_pkg::rec_t   rec_r, rec_nxt;

  // ---- memory and unit hookup ----
  logic             rd_en, wr_en;
  logic [SW-1:0]    rd_addr, wr_addr;
  aets_pkg::rec_t   rd_data, wr_data;
  logic             mul_en;
  logic signed [23:0] unit_cur, unit_res;
  logic signed [15:0] unit_goal;

  logic             in_fire;
  logic             rd_live;
  logic [8:0]       sel_ext, rs_ext;
  logic             rs_in_range;
  logic [SW-1:0]    rs_addr;
  logic signed [15:0] ty_in;

  aets_slot_ram #(
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  aets_approach u_approach (
    .clk    (clk),
    .mul_en (mul_en),
    .cur    (unit_cur),
    .goal   (unit_goal),
    .res    (unit_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_data_r.status;
  assign out_tdata  = {out_data_r.ttl, out_data_r.z, out_data_r.y, out_data_r.x,
                       out_data_r.color, out_data_r.id, out_data_r.slot};

  // a slot is live when written since the last clear and ttl is nonzero
  assign rd_live = valid_r[cmp_r] && (rd_data.ttl != 8'd0);

  assign sel_ext     = 9'(sel_r);
  assign rs_ext      = 9'(item_r.rs);
  assign rs_in_range = (rs_ext < 9'(SLOTS));
  assign rs_addr     = rs_ext[SW-1:0];

  // y negation wraps, so -32768 stays -32768
  assign ty_in = invert_y_r ? $signed(16'(16'd0 - in_tdata[67:52]))
                            : $signed(in_tdata[67:52]);

  // shared unit operand select
  always_comb begin
    unique case (axis_r)
      AX_Y: begin
        unit_cur  = rec_r.sy;
        unit_goal = rec_r.gy;
      end
      AX_Z: begin
        unit_cur  = rec_r.sz;
        unit_goal = rec_r.gz;
      end
      default: begin
        unit_cur  = rec_r.sx;
        unit_goal = rec_r.gx;
      end
    endcase
  end

  // configuration
  always_comb begin
    scene_key_nxt  = scene_key_r;
    invert_y_nxt   = invert_y_r;
    ttl_reload_nxt = ttl_reload_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aets_pkg::CFG_SCENE_KEY:  scene_key_nxt  = cfg_data;
        aets_pkg::CFG_INVERT_Y:   invert_y_nxt   = cfg_data[0];
        aets_pkg::CFG_TTL_RELOAD: ttl_reload_nxt = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    iss_done_nxt   = iss_done_r;
    pend_nxt       = 1'b0;
    match_nxt      = match_r;
    free_nxt       = free_r;
    idx_nxt        = idx_r;
    cmp_nxt        = cmp_r;
    msel_nxt       = msel_r;
    fsel_nxt       = fsel_r;
    sel_nxt        = sel_r;
    axis_nxt       = axis_r;
    item_nxt       = item_r;
    res_nxt        = res_r;
    rec_nxt        = rec_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rec_r;
    mul_en         = 1'b0;
    // output register drains independently of the sequencer
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt.id    = in_tdata[31:16];
          item_nxt.color = in_tdata[35:32];
          item_nxt.tx    = $signed(in_tdata[51:36]);
          item_nxt.ty    = ty_in;
          item_nxt.tz    = $signed(in_tdata[83:68]);
          item_nxt.rs    = in_tdata[87:84];
          res_nxt        = '0;
          idx_nxt        = '0;
          unique case (in_tuser)
            aets_pkg::CMD_UPDATE: begin
              if (in_tdata[15:0] != scene_key_r) begin
                res_nxt.status = aets_pkg::ST_MISMATCH;
                state_nxt      = S_DONE;
              end else begin
                iss_done_nxt = 1'b0;
                match_nxt    = 1'b0;
                free_nxt     = 1'b0;
                state_nxt    = S_USCAN;
              end
            end
            aets_pkg::CMD_TICK: begin
              state_nxt = S_TRD;
            end
            aets_pkg::CMD_READ: begin
              res_nxt.status = aets_pkg::ST_READ;
              res_nxt.slot   = in_tdata[87:84];
              state_nxt      = S_RRD;
            end
            default: begin
              // clear: only the slot valid bits go, stored values stay readable
              valid_nxt      = '0;
              res_nxt.status = aets_pkg::ST_CLEARED;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // one read issued and one slot compared per cycle
      S_USCAN: begin
        if (!iss_done_r) begin
          rd_en    = 1'b1;
          rd_addr  = idx_r;
          cmp_nxt  = idx_r;
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          if (idx_r == LAST) begin
            iss_done_nxt = 1'b1;
          end
        end
        if (pend_r) begin
          if (rd_live && (rd_data.id == item_r.id) && !match_r) begin
            match_nxt = 1'b1;
            msel_nxt  = cmp_r;
          end
          if (!rd_live && !free_r) begin
            free_nxt = 1'b1;
            fsel_nxt = cmp_r;
          end
          if (cmp_r == LAST) begin
            state_nxt = S_UDEC;
          end
        end
      end

      S_UDEC: begin
        if (match_r) begin
          sel_nxt   = msel_r;
          state_nxt = S_URD;
        end else if (free_r) begin
          sel_nxt   = fsel_r;
          state_nxt = S_URD;
        end else begin
          res_nxt.status = aets_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end
      end

      S_URD: begin
        rd_en     = 1'b1;
        rd_addr   = sel_r;
        cmp_nxt   = sel_r;
        state_nxt = S_UWR;
      end

      // refresh keeps the smoothed position, a new entry snaps to target
      S_UWR: begin
        wr_en         = 1'b1;
        wr_addr       = sel_r;
        wr_data       = rd_data;
        wr_data.id    = item_r.id;
        wr_data.color = item_r.color;
        wr_data.gx    = item_r.tx;
        wr_data.gy    = item_r.ty;
        wr_data.gz    = item_r.tz;
        wr_data.ttl   = ttl_reload_r;
        if (!match_r) begin
          wr_data.sx = {item_r.tx, 8'h00};
          wr_data.sy = {item_r.ty, 8'h00};
          wr_data.sz = {item_r.tz, 8'h00};
        end
        valid_nxt[sel_r] = 1'b1;
        res_nxt.status   = match_r ? aets_pkg::ST_REFRESH : aets_pkg::ST_NEW;
        res_nxt.slot     = sel_ext[3:0];
        state_nxt        = S_DONE;
      end

      S_TRD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        cmp_nxt   = idx_r;
        state_nxt = S_TLD;
      end

      S_TLD: begin
        rec_nxt = rd_data;
        if (rd_live) begin
          axis_nxt  = AX_X;
          state_nxt = S_TMUL;
        end else if (idx_r == LAST) begin
          res_nxt.status = aets_pkg::ST_TICKED;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TRD;
        end
      end

      S_TMUL: begin
        mul_en    = 1'b1;
        state_nxt = S_TACC;
      end

      S_TACC: begin
        unique case (axis_r)
          AX_Y:    rec_nxt.sy = unit_res;
          AX_Z:    rec_nxt.sz = unit_res;
          default: rec_nxt.sx = unit_res;
        endcase
        if (axis_r == AX_Z) begin
          state_nxt = S_TWR;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_TMUL;
        end
      end

      S_TWR: begin
        wr_en       = 1'b1;
        wr_addr     = idx_r;
        wr_data     = rec_r;
        wr_data.ttl = rec_r.ttl - 8'd1;
        if (idx_r == LAST) begin
          res_nxt.status = aets_pkg::ST_TICKED;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TRD;
        end
      end

      // a read beyond the table reports zeros
      S_RRD: begin
        if (rs_in_range) begin
          rd_en     = 1'b1;
          rd_addr   = rs_addr;
          cmp_nxt   = rs_addr;
          state_nxt = S_RLD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RLD: begin
        res_nxt.id    = rd_data.id;
        res_nxt.color = rd_data.color;
        res_nxt.x     = rd_data.sx;
        res_nxt.y     = rd_data.sy;
        res_nxt.z     = rd_data.sz;
        res_nxt.ttl   = valid_r[cmp_r] ? rd_data.ttl : 8'd0;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = res_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
      scene_key_r  <= 16'd0;
      invert_y_r   <= 1'b0;
      ttl_reload_r <= 8'd50;
      iss_done_r   <= 1'b0;
      pend_r       <= 1'b0;
      match_r      <= 1'b0;
      free_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      scene_key_r  <= scene_key_nxt;
      invert_y_r   <= invert_y_nxt;
      ttl_reload_r <= ttl_reload_nxt;
      iss_done_r   <= iss_done_nxt;
      pend_r       <= pend_nxt;
      match_r      <= match_nxt;
      free_r       <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cmp_r      <= cmp_nxt;
    msel_r     <= msel_nxt;
    fsel_r     <= fsel_nxt;
    sel_r      <= sel_nxt;
    axis_r     <= axis_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    rec_r      <= rec_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---- assertions ----

  // an update only writes a slot that the scan found
  a_uwr_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UWR) |-> (match_r || free_r))
    else $error("update write without a chosen slot");

  // a clear frees every slot by the next cycle
  a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == aets_pkg::CMD_CLEAR) |=> (valid_r == '0))
    else $error("clear left a slot valid");

  // the smoothing unit is only ever loaded for x, y or z
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TMUL) |-> (axis_r == AX_X || axis_r == AX_Y || axis_r == AX_Z))
    else $error("smoothing axis out of range");

  // a tick load always follows its memory read
  a_tld_after_trd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TLD) |-> ($past(state_r) == S_TRD))
    else $error("tick load without a preceding read");

endmodule

>>> rtl/aets_slot_ram.sv
// ----------------------------------------------------------------------------
// aets_slot_ram
// Slot record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module aets_slot_ram #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  aets_pkg::rec_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output aets_pkg::rec_t           rd_data
);

  aets_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/aets_approach.sv
// ----------------------------------------------------------------------------
// aets_approach
// Shared smoothing unit: cur + floor((goal*256 - cur) / 5), Q16.8.
// Product registered on mul_en, result valid the cycle after.
// ----------------------------------------------------------------------------
module aets_approach (
  input  logic               clk,
  input  logic               mul_en,
  input  logic signed [23:0] cur,
  input  logic signed [15:0] goal,
  output logic signed [23:0] res
);

  logic signed [24:0] diff;
  logic [26:0]        dividend;
  logic [58:0]        prod;
  logic [23:0]        quot_r;
  logic [23:0]        cur_r;

  // diff lies in [-2**24, 2**24), so biased dividend stays in [0, 2**27)
  assign diff     = {goal[15], goal, 8'h00} - {cur[23], cur};
  assign dividend = {{2{diff[24]}}, diff} + aets_pkg::DIV_BIAS;
  assign prod     = dividend * aets_pkg::RECIP5;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      // bias term 2**24 vanishes modulo 2**24
      quot_r <= prod[57:34];
      cur_r  <= cur;
    end
  end

  assign res = $signed(cur_r + quot_r);

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the aging entity table smoother. Directed items cover field
// extremes, every command and the table corner cases (key mismatch, table
// full, refresh, read after clear); random phases then sweep the registers
// under random stalls on both streams. Every result is checked field by
// field against an in-bench slot table tracker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NSLOT      = 16;
  localparam logic [1:0]  CFG_SPARE  = 2'd3;     // decoded by nothing
  localparam int          PHASES     = 6;
  localparam int          PHASE_LEN  = 155;
  localparam int          HOLD_AT    = 300;      // items taken before back-pressure
  localparam int          HOLD_LEN   = 400;      // cycles of back-pressure
  localparam int          DRAIN_WAIT = 160;      // longer than a full-table tick
  localparam int unsigned LIMIT      = 1000000;

  // one result item as it leaves the block
  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [15:0]        id;
    logic [3:0]         color;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [7:0]         ttl;
  } reply_t;

  // Tracks the slot table and the registers, and holds the replies due.
  class slot_table_tracker;
    logic [15:0]        scene_key;
    logic               invert_y;
    logic [7:0]         ttl_reload;
    logic [15:0]        ent_id    [NSLOT];
    logic [3:0]         ent_color [NSLOT];
    logic signed [15:0] gx [NSLOT];
    logic signed [15:0] gy [NSLOT];
    logic signed [15:0] gz [NSLOT];
    logic signed [23:0] sx [NSLOT];
    logic signed [23:0] sy [NSLOT];
    logic signed [23:0] sz [NSLOT];
    logic [7:0]         life      [NSLOT];
    bit                 written   [NSLOT];
    reply_t             due_replies [$];
    int                 fails;
    int                 taken;

    function new();
      scene_key  = '0;
      invert_y   = 1'b0;
      ttl_reload = 8'd50;
      fails      = 0;
      taken      = 0;
      foreach (life[i]) begin
        life[i]    = '0;
        written[i] = 1'b0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        aets_pkg::CFG_SCENE_KEY:  scene_key  = value;
        aets_pkg::CFG_INVERT_Y:   invert_y   = value[0];
        aets_pkg::CFG_TTL_RELOAD: ttl_reload = value[7:0];
        default: ;
      endcase
    endfunction

    // one fifth of the way toward goal*256, rounded toward minus infinity
    function logic signed [23:0] glide(logic signed [23:0] cur, logic signed [15:0] goal);
      int c;
      int d;
      int stp;
      c   = cur;
      d   = int'(goal) * 256 - c;
      stp = (d >= 0) ? d / 5 : -((4 - d) / 5);
      return 24'(c + stp);
    endfunction

    // a slot that holds data, so that a read never sees unwritten memory
    function int pick_written();
      int cand [$];
      foreach (written[i]) if (written[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void take_item(logic [1:0] cmd, logic [87:0] d);
      logic [15:0]        key;
      logic [15:0]        id;
      logic [3:0]         color;
      logic [3:0]         rs;
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic signed [15:0] tz;
      int                 hit;
      reply_t             r;
      key   = d[15:0];
      id    = d[31:16];
      color = d[35:32];
      tx    = d[51:36];
      ty    = d[67:52];
      tz    = d[83:68];
      rs    = d[87:84];
      r     = '0;
      hit   = -1;
      taken++;
      case (cmd)
        aets_pkg::CMD_UPDATE: begin
          if (key != scene_key) begin
            r.status = aets_pkg::ST_MISMATCH;
          end else begin
            // live slot with the same id first, then the lowest free one
            for (int i = 0; i < NSLOT; i++)
              if (hit < 0 && life[i] != 0 && ent_id[i] == id) hit = i;
            for (int i = 0; i < NSLOT; i++)
              if (hit < 0 && life[i] == 0) hit = i;
            if (hit < 0) begin
              r.status = aets_pkg::ST_FULL;
            end else begin
              if (invert_y) ty = -ty;   // -32768 wraps onto itself
              ent_id[hit]    = id;
              ent_color[hit] = color;
              gx[hit]        = tx;
              gy[hit]        = ty;
              gz[hit]        = tz;
              r.status       = aets_pkg::ST_REFRESH;
              if (life[hit] == 0) begin
                sx[hit]  = {tx, 8'h00};
                sy[hit]  = {ty, 8'h00};
                sz[hit]  = {tz, 8'h00};
                r.status = aets_pkg::ST_NEW;
              end
              life[hit]    = ttl_reload;
              written[hit] = 1'b1;
              r.slot       = 4'(hit);
            end
          end
        end
        aets_pkg::CMD_TICK: begin
          foreach (life[i]) begin
            if (life[i] != 0) begin
              sx[i] = glide(sx[i], gx[i]);
              sy[i] = glide(sy[i], gy[i]);
              sz[i] = glide(sz[i], gz[i]);
              life[i]--;
            end
          end
          r.status = aets_pkg::ST_TICKED;
        end
        aets_pkg::CMD_READ: begin
          r.status = aets_pkg::ST_READ;
          r.slot   = rs;
          r.id     = ent_id[rs];
          r.color  = ent_color[rs];
          r.cx     = sx[rs];
          r.cy     = sy[rs];
          r.cz     = sz[rs];
          r.ttl    = life[rs];
        end
        default: begin
          foreach (life[i]) life[i] = '0;
          r.status = aets_pkg::ST_CLEARED;
        end
      endcase
      due_replies.push_back(r);
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        fails++;
      end
    endfunction

    function void match_result(logic [2:0] st, logic [103:0] d);
      reply_t w;
      if (due_replies.size() == 0) begin
        $error("result with no item waiting: status %0d", st);
        fails++;
        return;
      end
      w = due_replies.pop_front();
      check_field("status",        w.status, st);
      check_field("slot_used",     w.slot,   d[3:0]);
      check_field("id_out",        w.id,     d[19:4]);
      check_field("color_out",     w.color,  d[23:20]);
      check_field("current_x_out", w.cx,     d[47:24]);
      check_field("current_y_out", w.cy,     d[71:48]);
      check_field("current_z_out", w.cz,     d[95:72]);
      check_field("ttl_out",       w.ttl,    d[103:96]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;
  logic [87:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [2:0]   out_tuser;
  logic [103:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  slot_table_tracker tracker = new();
  bit                idle_on = 1'b1;   // random stalls on both streams
  logic [15:0]       id_pool [32];
  int                pool_size = 8;
  int unsigned       cycles = 0;

  aging_entity_table_smoother_unit #(.SLOTS(NSLOT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: compare each accepted result with the oldest reply due
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_result(out_tuser, out_tdata);
  end

  // result side ready: short random stalls, plus one long hold that backs
  // the block up until in_tready drops
  initial begin : result_sink
    bit hold_done;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && tracker.taken >= HOLD_AT) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [87:0] pack_item(logic [15:0] key, logic [15:0] id,
      logic [3:0] color, logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [3:0] rs);
    return {rs, z, y, x, color, id, key};
  endfunction

  // target coordinate: extremes often, values near the origin sometimes
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one item, optionally after a short gap; valid stays up after the
  // handshake so back-to-back items need no second assignment
  task automatic send_item(logic [1:0] cmd, logic [87:0] d);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    tracker.take_item(cmd, d);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid before the block frees up, so the last item is not taken twice
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.due_replies.size() != 0) @(posedge clk);
  endtask

  // mostly matching updates from a small id pool so the table fills, ages
  // and refreshes; some foreign keys, ticks, reads of written slots, clears
  task automatic random_item();
    logic [1:0]  cmd;
    logic [15:0] key;
    int          pick;
    int          rs;
    pick = $urandom_range(0, 99);
    rs   = $urandom_range(0, NSLOT - 1);
    key  = 16'($urandom);
    if (pick < 50) begin
      cmd = aets_pkg::CMD_UPDATE;
      if ($urandom_range(0, 11) != 0) key = tracker.scene_key;
    end else if (pick < 72) begin
      cmd = aets_pkg::CMD_TICK;
    end else if (pick < 97) begin
      cmd = aets_pkg::CMD_READ;
      rs  = tracker.pick_written();
      if (rs < 0) begin
        cmd = aets_pkg::CMD_TICK;
        rs  = $urandom_range(0, NSLOT - 1);
      end
    end else begin
      cmd = aets_pkg::CMD_CLEAR;
    end
    send_item(cmd, pack_item(key, id_pool[$urandom_range(0, pool_size - 1)],
                             4'($urandom), rand_coord(), rand_coord(), rand_coord(),
                             4'(rs)));
  endtask

  initial begin : stimulus
    logic [15:0] ph_key [PHASES];
    logic        ph_inv [PHASES];
    logic [7:0]  ph_ttl [PHASES];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    ph_key = '{16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom), 16'($urandom), 16'h5A5A};
    ph_inv = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    ph_ttl = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd20, 8'd8};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset register values (key 0, ttl 50)
    send_item(aets_pkg::CMD_UPDATE, pack_item(16'h0000, 16'h0000, 4'h0, 16'h8000,
                                              16'h7FFF, 16'h0000, 4'h0));
    send_item(aets_pkg::CMD_UPDATE, pack_item(16'h0000, 16'hFFFF, 4'hF, 16'h7FFF,
                                              16'h8000, 16'hFFFF, 4'hF));
    // foreign key is dropped
    send_item(aets_pkg::CMD_UPDATE, pack_item(16'hFFFF, 16'h1234, 4'h5, 16'h0001,
                                              16'h0002, 16'h0003, 4'h0));
    // same id again: refresh keeps the smoothed position, far new target
    send_item(aets_pkg::CMD_UPDATE, pack_item(16'h0000, 16'hFFFF, 4'hA, 16'h8000,
                                              16'h7FFF, 16'h0123, 4'h0));
    send_item(aets_pkg::CMD_TICK, pack_item(16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF,
                                            16'hFFFF, 16'hFFFF, 4'hF));
    send_item(aets_pkg::CMD_TICK, '0);
    send_item(aets_pkg::CMD_READ, pack_item(16'h0000, 16'h0000, 4'h0, 16'h0000,
                                            16'h0000, 16'h0000, 4'd0));
    send_item(aets_pkg::CMD_READ, pack_item(16'h0000, 16'h0000, 4'h0, 16'h0000,
                                            16'h0000, 16'h0000, 4'd1));
    send_item(aets_pkg::CMD_CLEAR, '0);
    // freed slot still reports what it held, with ttl 0
    send_item(aets_pkg::CMD_READ, pack_item(16'h0000, 16'h0000, 4'h0, 16'h0000,
                                            16'h0000, 16'h0000, 4'd1));
    for (int i = 0; i < NSLOT; i++)
      send_item(aets_pkg::CMD_UPDATE,
                pack_item(16'h0000, 16'h0100 + 16'(i), 4'(i), rand_coord(),
                          rand_coord(), rand_coord(), 4'(i)));
    // seventeenth id finds no room
    send_item(aets_pkg::CMD_UPDATE, pack_item(16'h0000, 16'hBEEF, 4'h3, 16'h0010,
                                              16'h0020, 16'h0030, 4'h0));
    send_item(aets_pkg::CMD_READ, pack_item(16'h0000, 16'h0000, 4'h0, 16'h0000,
                                            16'h0000, 16'h0000, 4'd15));

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_cfg(aets_pkg::CFG_SCENE_KEY, ph_key[p]);
      write_cfg(aets_pkg::CFG_INVERT_Y, {15'($urandom), ph_inv[p]});
      write_cfg(aets_pkg::CFG_TTL_RELOAD, {8'($urandom), ph_ttl[p]});
      if (p == 2) write_cfg(CFG_SPARE, 16'($urandom));
      idle_on   = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      pool_size = $urandom_range(6, 28);
      foreach (id_pool[i]) id_pool[i] = 16'($urandom);
      repeat (PHASE_LEN) random_item();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
